FILE: rtl/cpue_pkg.sv
// Package for the code point unit encoder: payload types, decoded item bundle, codes.
`default_nettype none
package cpue_pkg;

    // Width codes of the unit width register
    localparam logic [1:0] WIDTH_BYTE = 2'd0;
    localparam logic [1:0] WIDTH_HALF = 2'd1;
    localparam logic [1:0] WIDTH_WORD = 2'd2;

    // Register map
    localparam int unsigned ADDR_BITS      = 3;
    localparam logic        REG_UNIT_WIDTH = 1'b0;  // word index in paddr[2]

    // Input item actions
    localparam logic ACT_ENCODE    = 1'b0;
    localparam logic ACT_TERMINATE = 1'b1;

    // Input item
    typedef struct packed {
        logic        action;
        logic [63:0] code_value;
        logic        raw;
    } cpue_in_t;

    // Result item
    typedef struct packed {
        logic [31:0] unit;
        logic        last_unit;
        logic        truncated;
        logic [15:0] unit_count;
    } cpue_out_t;

    // One decoded item: up to four units waiting for the result channel
    typedef struct packed {
        logic [3:0][31:0] units;
        logic [1:0]       last_idx;
        logic             truncated;
        logic             terminate;
    } cpue_dec_t;

endpackage
`default_nettype wire

FILE: rtl/code_point_unit_encoder.sv
// Top level of the code point unit encoder: register port, decode and unit serializer.
//
// Each input transfer is decoded in the cycle it is accepted and parked in a hold
// stage; the serializer then moves one code unit per cycle, unless the result side
// stalls, into the result register. An item has one unit for a raw value, a
// terminator or a single unit, two for a surrogate pair or a two-byte UTF-8
// sequence, three or four for a three- or four-byte one. The next item is accepted
// in the cycle the last unit of the current one moves to the result register, so
// single-unit items stream at one per cycle unless stalled. The user must write the
// unit width register at byte address 0 only while idle; this is not enforced.
`default_nettype none
module code_point_unit_encoder #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // APB register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cpue_pkg::ADDR_BITS-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    // Input items
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire cpue_pkg::cpue_in_t                s_data,
    // Result units
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output cpue_pkg::cpue_out_t                    m_data
);

    logic [1:0]          width_reg;
    cpue_pkg::cpue_dec_t dec;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == cpue_pkg::REG_UNIT_WIDTH);

    // Unit width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= cpue_pkg::WIDTH_BYTE;
        end else if (psel && penable && pwrite && reg_sel) begin
            width_reg <= pwdata[1:0];
        end
    end

    assign prdata = reg_sel ? {30'd0, width_reg} : 32'd0;

    cpue_decode u_decode (
        .width_code (width_reg),
        .item       (s_data),
        .dec        (dec)
    );

    cpue_serializer #(
        .COUNT_BITS (COUNT_BITS)
    ) u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_dec    (dec),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

endmodule
`default_nettype wire

FILE: rtl/cpue_decode.sv
// Combinational decode of one input item into its code units.
`default_nettype none
module cpue_decode (
    input  wire logic [1:0]       width_code,
    input  wire cpue_pkg::cpue_in_t item,
    output cpue_pkg::cpue_dec_t     dec
);

    always_comb begin
        logic [63:0] v;
        logic [31:0] mask;
        logic        over;
        logic [25:0] d;

        v = item.code_value;
        d = v[25:0] - 26'h10000;

        // Unit mask and raw overflow per width
        case (width_code)
            cpue_pkg::WIDTH_BYTE: begin
                mask = 32'h0000_00FF;
                over = |v[63:8];
            end
            cpue_pkg::WIDTH_HALF: begin
                mask = 32'h0000_FFFF;
                over = |v[63:16];
            end
            default: begin
                mask = 32'hFFFF_FFFF;
                over = |v[63:32];
            end
        endcase

        dec           = '0;
        dec.units[0]  = v[31:0] & mask;

        if (item.action == cpue_pkg::ACT_TERMINATE) begin
            // Zero terminator
            dec.units[0]  = '0;
            dec.terminate = 1'b1;
        end else if (item.raw) begin
            dec.truncated = over;
        end else if (width_code == cpue_pkg::WIDTH_BYTE) begin
            // UTF-8: lead byte then continuation bytes
            if (~|v[63:7]) begin
                dec.last_idx = 2'd0;
            end else if (~|v[63:11]) begin
                dec.units[0] = {24'd0, 8'hC0 | v[13:6]};
                dec.units[1] = {24'd0, 2'b10, v[5:0]};
                dec.last_idx = 2'd1;
            end else if (~|v[63:16]) begin
                dec.units[0] = {24'd0, 8'hE0 | v[19:12]};
                dec.units[1] = {24'd0, 2'b10, v[11:6]};
                dec.units[2] = {24'd0, 2'b10, v[5:0]};
                dec.last_idx = 2'd2;
            end else begin
                dec.units[0] = {24'd0, 8'hF0 | v[25:18]};
                dec.units[1] = {24'd0, 2'b10, v[17:12]};
                dec.units[2] = {24'd0, 2'b10, v[11:6]};
                dec.units[3] = {24'd0, 2'b10, v[5:0]};
                dec.last_idx = 2'd3;
            end
        end else if (width_code == cpue_pkg::WIDTH_HALF && (|v[63:16])) begin
            // UTF-16 surrogate pair
            dec.units[0] = {16'd0, 16'hD800 | d[25:10]};
            dec.units[1] = {16'd0, 6'b110111, d[9:0]};
            dec.last_idx = 2'd1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cpue_serializer.sv
// Holds one decoded item; issues units one per cycle to the result unless stalled.
`default_nettype none
module cpue_serializer #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cpue_pkg::cpue_dec_t in_dec,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cpue_pkg::cpue_out_t      out_item
);

    logic                   hold_valid_reg;
    cpue_pkg::cpue_dec_t    hold_reg;
    logic [1:0]             idx_reg;
    logic                   out_valid_reg;
    cpue_pkg::cpue_out_t    out_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;

    logic                   out_load;
    logic                   at_last;
    logic                   accept;
    logic [COUNT_BITS-1:0]  cnt_next;
    logic [COUNT_BITS+15:0] cnt_ext;

    // Move one unit forward whenever the result register is free or draining
    assign out_load = hold_valid_reg && (!out_valid_reg || out_ready);
    assign at_last  = (idx_reg == hold_reg.last_idx);
    assign in_ready = !hold_valid_reg || (out_load && at_last);
    assign accept   = in_valid && in_ready;

    // Saturating unit count
    assign cnt_next = (cnt_reg == {COUNT_BITS{1'b1}}) ? cnt_reg :
                      cnt_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign cnt_ext  = {16'd0, cnt_next};

    // Hold stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
            idx_reg        <= '0;
        end else if (out_load) begin
            if (at_last) begin
                hold_valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Hold stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg <= in_dec;
        end
    end

    // Result register control and unit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
            cnt_reg       <= hold_reg.terminate ? '0 : cnt_next;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.unit       <= hold_reg.units[idx_reg];
            out_reg.last_unit  <= at_last;
            out_reg.truncated  <= hold_reg.truncated;
            out_reg.unit_count <= cnt_ext[15:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
`default_nettype wire

FILE: rtl/cpue_checker.sv
// Port-level assertions for the code point unit encoder and their bind.
`default_nettype none
module cpue_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire cpue_pkg::cpue_out_t m_data
);

    // A stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A truncated raw value is always a single, final unit
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.truncated |-> m_data.last_unit)
        else $error("truncated unit not last");

    // The count includes the current unit, so it is never zero
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.unit_count != 16'd0)
        else $error("unit count zero on a result");

endmodule

bind code_point_unit_encoder cpue_checker u_cpue_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the code point unit encoder: directed and random literals.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Reserved width code, behaves as four-byte units
    localparam logic [1:0]                     WIDTH_RESERVED  = 2'd3;
    localparam logic [cpue_pkg::ADDR_BITS-1:0] UNIT_WIDTH_ADDR =
        {cpue_pkg::REG_UNIT_WIDTH, 2'b00};
    localparam logic [15:0]                    COUNT_MAX       = 16'hFFFF;
    localparam int unsigned                    CYCLE_LIMIT     = 400_000;
    // Length of the long literal of four-byte code points
    localparam int unsigned                    LONG_ITEMS      = 40;
    localparam int unsigned                    MAX_PRINTED     = 40;

    // Tracks the literal count and the code units still owed by the encoder
    class unit_scoreboard;
        logic [1:0]          width_code;
        logic [15:0]         units_emitted;
        cpue_pkg::cpue_out_t pending_units[$];
        int unsigned         fail_count;
        int unsigned         printed;

        function new();
            width_code    = cpue_pkg::WIDTH_BYTE;
            units_emitted = '0;
            fail_count    = 0;
            printed       = 0;
        endfunction

        task report(string msg);
            fail_count++;
            if (printed < MAX_PRINTED) begin
                $display("mismatch at %0t: %s", $realtime, msg);
                printed++;
            end
        endtask

        // One expected unit; the count is taken after this unit is counted
        function void push_unit(logic [63:0] value, logic [63:0] mask, bit trunc, bit last);
            cpue_pkg::cpue_out_t u;
            if (units_emitted != COUNT_MAX) units_emitted++;
            u.unit       = 32'(value & mask);
            u.last_unit  = last;
            u.truncated  = trunc;
            u.unit_count = units_emitted;
            pending_units.push_back(u);
        endfunction

        // Expected code units for one accepted input transfer
        function void note_item(cpue_pkg::cpue_in_t item);
            logic [63:0] v;
            logic [63:0] mask;
            logic [63:0] d;
            v = item.code_value;
            case (width_code)
                cpue_pkg::WIDTH_BYTE: mask = 64'hFF;
                cpue_pkg::WIDTH_HALF: mask = 64'hFFFF;
                default:              mask = 64'hFFFF_FFFF;
            endcase
            if (item.action == cpue_pkg::ACT_TERMINATE) begin
                push_unit(64'd0, mask, 1'b0, 1'b1);
                units_emitted = '0;
            end else if (item.raw) begin
                push_unit(v, mask, v > mask, 1'b1);
            end else if (width_code == cpue_pkg::WIDTH_BYTE) begin
                if (v < 64'h80) begin
                    push_unit(v, mask, 1'b0, 1'b1);
                end else if (v < 64'h800) begin
                    push_unit(64'hC0 | (v >> 6), mask, 1'b0, 1'b0);
                    push_unit(64'h80 | (v & 64'h3F), mask, 1'b0, 1'b1);
                end else if (v < 64'h10000) begin
                    push_unit(64'hE0 | (v >> 12), mask, 1'b0, 1'b0);
                    push_unit(64'h80 | ((v >> 6) & 64'h3F), mask, 1'b0, 1'b0);
                    push_unit(64'h80 | (v & 64'h3F), mask, 1'b0, 1'b1);
                end else begin
                    push_unit(64'hF0 | (v >> 18), mask, 1'b0, 1'b0);
                    push_unit(64'h80 | ((v >> 12) & 64'h3F), mask, 1'b0, 1'b0);
                    push_unit(64'h80 | ((v >> 6) & 64'h3F), mask, 1'b0, 1'b0);
                    push_unit(64'h80 | (v & 64'h3F), mask, 1'b0, 1'b1);
                end
            end else if (width_code == cpue_pkg::WIDTH_HALF && v > 64'hFFFF) begin
                // surrogate pair
                d = v - 64'h10000;
                push_unit(64'hD800 | (d >> 10), mask, 1'b0, 1'b0);
                push_unit(64'hDC00 | (d & 64'h3FF), mask, 1'b0, 1'b1);
            end else begin
                push_unit(v, mask, 1'b0, 1'b1);
            end
        endfunction

        // Compare one result transfer against the oldest expected unit
        task check_unit(cpue_pkg::cpue_out_t got);
            cpue_pkg::cpue_out_t want;
            if (pending_units.size() == 0) begin
                report($sformatf("unexpected unit %h count %0d", got.unit, got.unit_count));
                return;
            end
            want = pending_units.pop_front();
            if (got.unit !== want.unit)
                report($sformatf("unit %h, expected %h", got.unit, want.unit));
            if (got.last_unit !== want.last_unit)
                report($sformatf("last_unit %b, expected %b", got.last_unit, want.last_unit));
            if (got.truncated !== want.truncated)
                report($sformatf("truncated %b, expected %b", got.truncated, want.truncated));
            if (got.unit_count !== want.unit_count)
                report($sformatf("unit_count %0d, expected %0d",
                                 got.unit_count, want.unit_count));
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [cpue_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           s_valid;
    logic                           s_ready;
    cpue_pkg::cpue_in_t             s_data;
    logic                           m_valid;
    logic                           m_ready;
    cpue_pkg::cpue_out_t            m_data;

    unit_scoreboard sb = new();
    bit             idle_enable;
    int unsigned    cycle_count;

    code_point_unit_encoder #(
        .COUNT_BITS(16)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts while idling is enabled
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result transfers
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_unit(m_data);
    end

    function automatic cpue_pkg::cpue_in_t make_item(logic act, logic [63:0] v, logic r);
        cpue_pkg::cpue_in_t item;
        item.action     = act;
        item.code_value = v;
        item.raw        = r;
        return item;
    endfunction

    // Terminator with junk in the ignored fields
    function automatic cpue_pkg::cpue_in_t terminator();
        return make_item(cpue_pkg::ACT_TERMINATE, {$urandom, $urandom},
                         1'($urandom_range(0, 1)));
    endfunction

    // One literal element spread over all UTF-8 lengths, surrogates,
    // supplementary planes, values outside the code space and raw escapes
    function automatic cpue_pkg::cpue_in_t random_element();
        int unsigned pick;
        logic [63:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 18)      v = 64'($urandom_range(0, 32'h7F));
        else if (pick < 32) v = 64'($urandom_range(32'h80, 32'h7FF));
        else if (pick < 46) v = 64'($urandom_range(32'h800, 32'hFFFF));
        else if (pick < 51) v = 64'($urandom_range(32'hD800, 32'hDFFF));
        else if (pick < 66) v = 64'($urandom_range(32'h10000, 32'h10FFFF));
        else if (pick < 72) v = {$urandom, $urandom};
        else if (pick < 80) v = {$urandom, $urandom} >> $urandom_range(0, 63);
        else if (pick < 88)
            return make_item(cpue_pkg::ACT_ENCODE, 64'($urandom_range(0, 32'h1FF)), 1'b1);
        else
            return make_item(cpue_pkg::ACT_ENCODE,
                             {$urandom, $urandom} >> $urandom_range(0, 63), 1'b1);
        return make_item(cpue_pkg::ACT_ENCODE, v, 1'b0);
    endfunction

    // Input side: entered and left at a falling edge, valid held until the transfer
    task automatic send_item(cpue_pkg::cpue_in_t item);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(item);
        @(negedge aclk);
    endtask

    // Wait for every owed unit, then let the pipeline settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_units.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Write the unit width register, then read it back
    task automatic set_unit_width(logic [1:0] code);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= UNIT_WIDTH_ADDR;
        pwdata  <= 32'(code);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.width_code = code;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[1:0] !== code)
            sb.report($sformatf("unit width reads %h, written %h", prdata[1:0], code));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random literals, some left unterminated; optional idling per literal
    task automatic run_literals(int unsigned n_items, bit allow_idle);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items) begin
            idle_enable = allow_idle && ($urandom_range(0, 3) != 0);
            len = $urandom_range(0, 12);
            repeat (len) begin
                send_item(random_element());
                sent++;
            end
            if ($urandom_range(0, 9) != 0) begin
                send_item(terminator());
                sent++;
            end
        end
    endtask

    // Main sequence
    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        idle_enable = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // UTF-8 boundaries, a surrogate, a value outside the code space, raw bytes
        set_unit_width(cpue_pkg::WIDTH_BYTE);
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h0, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h7F, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h80, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h7FF, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h800, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hFFFF, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h10000, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h10FFFF, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hD800, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hFF, 1'b1));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h100, 1'b1));
        send_item(make_item(cpue_pkg::ACT_TERMINATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        wait_drained();

        // UTF-16: largest single unit, surrogate pairs, lone surrogate, raw overflow
        set_unit_width(cpue_pkg::WIDTH_HALF);
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hFFFF, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h10000, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h10FFFF, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hDFFF, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h10000, 1'b1));
        send_item(make_item(cpue_pkg::ACT_TERMINATE, 64'h0, 1'b0));
        wait_drained();

        // Reserved width code acts as four-byte units
        set_unit_width(WIDTH_RESERVED);
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hFFFF_FFFF, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h1_0000_0000, 1'b0));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hFFFF_FFFF, 1'b1));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h1_0000_0000, 1'b1));
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send_item(make_item(cpue_pkg::ACT_TERMINATE, 64'h0, 1'b1));
        wait_drained();

        // One long literal of four-byte sequences at full rate
        set_unit_width(cpue_pkg::WIDTH_BYTE);
        idle_enable = 1'b0;
        repeat (LONG_ITEMS)
            send_item(make_item(cpue_pkg::ACT_ENCODE,
                                64'($urandom_range(32'h10000, 32'h10FFFF)), 1'b0));
        send_item(terminator());
        send_item(make_item(cpue_pkg::ACT_ENCODE, 64'h41, 1'b0));
        send_item(terminator());
        wait_drained();

        // Random literals across all width settings
        set_unit_width(cpue_pkg::WIDTH_WORD);
        run_literals(70, 1'b1);
        wait_drained();
        set_unit_width(cpue_pkg::WIDTH_BYTE);
        run_literals(80, 1'b1);
        wait_drained();
        set_unit_width(WIDTH_RESERVED);
        run_literals(50, 1'b1);
        wait_drained();
        set_unit_width(cpue_pkg::WIDTH_HALF);
        run_literals(80, 1'b1);
        wait_drained();

        // Closing stretch at full rate
        set_unit_width(cpue_pkg::WIDTH_BYTE);
        run_literals(50, 1'b0);
        idle_enable = 1'b0;
        wait_drained();

        if (sb.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cpue_pkg.sv
rtl/cpue_decode.sv
rtl/cpue_serializer.sv
rtl/code_point_unit_encoder.sv
rtl/cpue_checker.sv
sim/tb_top.sv
